@@ hdl/akpc_pkg.sv @@
// ----------------------------------------------------------------------------
// akpc_pkg
// Types and constants shared by the analog keypad press counter modules.
// ----------------------------------------------------------------------------
package akpc_pkg;

  localparam int SAMPLE_W       = 10;
  localparam int TIME_W         = 32;
  localparam int MS_W           = 16;
  localparam int COUNT_W        = 16;
  localparam int OUT_KEYS       = 5;
  localparam int NUM_LEVEL_REGS = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0_LEVEL  = 3'd0,
    REG_KEY1_LEVEL  = 3'd1,
    REG_KEY2_LEVEL  = 3'd2,
    REG_KEY3_LEVEL  = 3'd3,
    REG_KEY4_LEVEL  = 3'd4,
    REG_MATCH_TOL   = 3'd5,
    REG_SHORT_MIN   = 3'd6,
    REG_LONG_PRESS  = 3'd7
  } cfg_reg_t;

  localparam logic [SAMPLE_W-1:0] LEVEL_RESET [NUM_LEVEL_REGS] =
    '{10'd683, 10'd768, 10'd819, 10'd513, 10'd0};
  localparam logic [SAMPLE_W-1:0] TOL_RESET        = 10'd5;
  localparam logic [MS_W-1:0]     SHORT_MIN_RESET  = 16'd10;
  localparam logic [MS_W-1:0]     LONG_PRESS_RESET = 16'd1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
  } key_in_t;

  typedef struct packed {
    logic [OUT_KEYS-1:0]       held_mask;
    logic [OUT_KEYS-1:0]       short_mask;
    logic [OUT_KEYS-1:0]       long_mask;
    logic signed [COUNT_W-1:0] count0;
    logic signed [COUNT_W-1:0] count1;
    logic signed [COUNT_W-1:0] count2;
    logic signed [COUNT_W-1:0] count3;
    logic signed [COUNT_W-1:0] count4;
  } key_out_t;

  typedef struct packed {
    logic [NUM_LEVEL_REGS-1:0][SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0]                     tol;
    logic [MS_W-1:0]                         short_min;
    logic [MS_W-1:0]                         long_ms;
  } akpc_cfg_t;

  typedef struct packed {
    logic               held;
    logic               short_hit;
    logic               long_hit;
    logic [COUNT_W-1:0] count;
  } lane_res_t;

endpackage

@@ hdl/akpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// akpc_cfg_regs
// Configuration register file: key levels, match tolerance and time limits.
// ----------------------------------------------------------------------------
module akpc_cfg_regs
  import akpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output akpc_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVEL_REGS; i++) begin
        cfg.level[i] <= LEVEL_RESET[i];
      end
      cfg.tol       <= TOL_RESET;
      cfg.short_min <= SHORT_MIN_RESET;
      cfg.long_ms   <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY0_LEVEL: cfg.level[0] <= cfg_data[SAMPLE_W-1:0];
        REG_KEY1_LEVEL: cfg.level[1] <= cfg_data[SAMPLE_W-1:0];
        REG_KEY2_LEVEL: cfg.level[2] <= cfg_data[SAMPLE_W-1:0];
        REG_KEY3_LEVEL: cfg.level[3] <= cfg_data[SAMPLE_W-1:0];
        REG_KEY4_LEVEL: cfg.level[4] <= cfg_data[SAMPLE_W-1:0];
        REG_MATCH_TOL:  cfg.tol       <= cfg_data[SAMPLE_W-1:0];
        REG_SHORT_MIN:  cfg.short_min <= cfg_data[MS_W-1:0];
        REG_LONG_PRESS: cfg.long_ms   <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/akpc_key_lane.sv @@
// ----------------------------------------------------------------------------
// akpc_key_lane
// Per-key match, press timing and press count for one keypad key.
// ----------------------------------------------------------------------------
module akpc_key_lane
  import akpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [SAMPLE_W-1:0] level,
  input  logic [SAMPLE_W-1:0] tol,
  input  logic [MS_W-1:0]     short_min,
  input  logic [MS_W-1:0]     long_ms,
  output lane_res_t           res
);

  logic               held;
  logic               armed;
  logic [TIME_W-1:0]  start;
  logic [COUNT_W-1:0] count;

  logic [SAMPLE_W-1:0] delta;
  logic                match;
  logic                fresh;
  logic                armed_eff;
  logic                armed_next;
  logic [TIME_W-1:0]   start_next;
  logic [TIME_W-1:0]   elapsed;
  logic                short_hit;
  logic                long_hit;
  logic [COUNT_W-1:0]  count_next;

  always_comb begin
    delta      = (sample >= level) ? (sample - level) : (level - sample);
    match      = delta < tol;
    fresh      = match && !held;
    start_next = fresh ? now_ms : start;
    armed_eff  = fresh || armed;
    elapsed    = now_ms - start_next;
    short_hit  = armed_eff && held && !match &&
                 (elapsed > {{(TIME_W-MS_W){1'b0}}, short_min}) &&
                 (elapsed < {{(TIME_W-MS_W){1'b0}}, long_ms});
    long_hit   = armed_eff && held && match &&
                 (elapsed > {{(TIME_W-MS_W){1'b0}}, long_ms});
    armed_next = armed_eff && !long_hit;
    count_next = count;
    if (short_hit) begin
      count_next = count + 16'd1;
    end else if (long_hit) begin
      count_next = count - 16'd1;
    end
  end

  assign res.held      = match;
  assign res.short_hit = short_hit;
  assign res.long_hit  = long_hit;
  assign res.count     = count_next;

  // Commit the step only when the beat moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      armed <= 1'b0;
      start <= '0;
      count <= '0;
    end else if (advance) begin
      held  <= match;
      armed <= armed_next;
      start <= start_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/analog_keypad_press_counter.sv @@
// ----------------------------------------------------------------------------
// analog_keypad_press_counter
// Resistor-ladder keypad decoder that counts short and long key presses.
// ----------------------------------------------------------------------------
// Each input beat carries one ADC sample of the keypad ladder and a free
// running millisecond timestamp. Key k is held while the sample lies strictly
// within match_tolerance of its level. Releasing an armed key after more than
// short_min_ms and less than long_press_ms adds one to its signed 16-bit count;
// holding it past long_press_ms subtracts one once and disarms it. Every input
// beat yields exactly one result beat with the held, short and long masks and
// all five counts after the step. The block takes one beat per cycle while the
// result side does not stall: a beat sits in the input register while the
// per-key lanes compare and update, then lands in the result register, from
// which the result is taken. A stall on the result side holds the result
// register and then the input register; the input accepts again as soon as
// the input register is free. Write configuration only while idle.
// ----------------------------------------------------------------------------
module analog_keypad_press_counter
  import akpc_pkg::*;
#(
  parameter int NUM_KEYS = 5
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  key_in_t               in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output key_out_t              out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Keys beyond the visible five never show up on the result, so build no lane.
  localparam int LANES = (NUM_KEYS < OUT_KEYS) ? NUM_KEYS : OUT_KEYS;

  akpc_cfg_t cfg;

  logic    s1_valid;
  key_in_t s1_beat;
  logic    advance;
  logic    take;

  lane_res_t [OUT_KEYS-1:0] lane_res;
  key_out_t                 result;

  akpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the input-register beat whenever the result register is free
  // or being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  genvar k;
  generate
    for (k = 0; k < OUT_KEYS; k++) begin : g_lane
      if (k < LANES) begin : g_on
        akpc_key_lane u_lane (
          .clk       (clk),
          .rst       (rst),
          .advance   (advance),
          .sample    (s1_beat.sample),
          .now_ms    (s1_beat.now_ms),
          .level     (cfg.level[k]),
          .tol       (cfg.tol),
          .short_min (cfg.short_min),
          .long_ms   (cfg.long_ms),
          .res       (lane_res[k])
        );
      end else begin : g_off
        // Unbuilt keys report nothing held and a zero count.
        assign lane_res[k] = '0;
      end
    end
  endgenerate

  // Gather the lane results into one result beat.
  always_comb begin
    for (int i = 0; i < OUT_KEYS; i++) begin
      result.held_mask[i]  = lane_res[i].held;
      result.short_mask[i] = lane_res[i].short_hit;
      result.long_mask[i]  = lane_res[i].long_hit;
    end
    result.count0 = signed'(lane_res[0].count);
    result.count1 = signed'(lane_res[1].count);
    result.count2 = signed'(lane_res[2].count);
    result.count3 = signed'(lane_res[3].count);
    result.count4 = signed'(lane_res[4].count);
  end

  // Pipeline control: input register then result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new beat arrives.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_beat <= in_beat;
    end
    if (advance) begin
      out_beat <= result;
    end
  end

  // A key cannot finish a short press and a long press on the same beat.
  a_short_long_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_beat.short_mask & out_beat.long_mask) == '0))
    else $error("short and long press on the same key");

  // A short press is counted on release, so the key is no longer held.
  a_short_released: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_beat.short_mask & out_beat.held_mask) == '0))
    else $error("short press reported on a held key");

  // Input backs up only when both stages are full and the output stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated after drain");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
